### hw/rtl/polar_vector_add_defines.svh
`ifndef POLAR_VECTOR_ADD_DEFINES_SVH
`define POLAR_VECTOR_ADD_DEFINES_SVH

`ifndef SYNTH

`define PVA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pva assertion failed");

`define PVA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pva assertion failed");

`else

`define PVA_ASSERT_NOW(lbl, ante, cons)

`define PVA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/pva_pkg.sv
package pva_pkg;

    localparam int MAG_BITS   = 16;
    localparam int ANGLE_BITS = 16;
    localparam int GUARD_BITS = 16;
    localparam int STAGES_DEF = 16;
    localparam int QDEPTH     = 4;
    localparam int CW         = MAG_BITS + GUARD_BITS + 5;
    localparam int ANG_SHIFT  = 32 - ANGLE_BITS;
    localparam logic [31:0] ANG_HALF = 32'd1 << (ANG_SHIFT - 1);
    localparam logic [31:0] ANG_PI   = 32'h8000_0000;

    typedef logic signed [CW-1:0] t_comp;

    typedef struct packed {
        logic signed [MAG_BITS-1:0]   mag_a;
        logic signed [ANGLE_BITS-1:0] angle_a;
        logic signed [MAG_BITS-1:0]   mag_b;
        logic signed [ANGLE_BITS-1:0] angle_b;
    } t_req;

    typedef struct packed {
        logic [MAG_BITS:0]            sum_mag;
        logic signed [ANGLE_BITS-1:0] sum_angle;
    } t_res;

    typedef struct packed {
        t_comp x;
        t_comp y;
    } t_sum;

    typedef struct packed {
        t_comp       x;
        t_comp       y;
        logic [31:0] z;
        logic        flip;
    } t_rot;

    typedef struct packed {
        t_comp       x;
        t_comp       y;
        logic [31:0] z;
        logic        zero;
    } t_vec;

    function automatic logic [31:0] atan_units(input logic [4:0] s);
        logic [31:0] v;
        case (s)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] cordic_gain(input int n);
        logic [63:0] g;
        logic [63:0] d;
        logic [63:0] q;
        logic [64:0] rem;
        g = 64'd1 << 32;
        for (int i = 0; i < n; i++) begin
            d   = (64'd1 << (2 * (i & 31))) + 64'd1;
            q   = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[63:0], g[b]};
                if (rem >= {1'b0, d}) begin
                    rem  = rem - {1'b0, d};
                    q[b] = 1'b1;
                end
            end
            g = g - q;
        end
        return g[31:0];
    endfunction

endpackage

### hw/rtl/pva_front.sv
module pva_front import pva_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    input  logic i_full,
    output logic o_busy,
    output logic o_push,
    output t_sum o_sum
);

    function automatic t_rot rot_prep(input logic signed [MAG_BITS-1:0] m,
                                      input logic signed [ANGLE_BITS-1:0] a);
        t_rot  r;
        t_comp ax;
        ax = t_comp'(m);
        if (ax < 0) begin
            ax = -ax;
        end
        r.flip = m[MAG_BITS-1];
        r.x    = ax <<< GUARD_BITS;
        r.y    = '0;
        r.z    = {a, {ANG_SHIFT{1'b0}}};
        if (r.z[31] ^ r.z[30]) begin
            r.x     = -r.x;
            r.z[31] = ~r.z[31];
        end
        return r;
    endfunction

    function automatic t_rot rot_step(input t_rot r, input logic [4:0] s);
        t_rot  o;
        t_comp dx;
        t_comp dy;
        dx = r.y >>> s;
        dy = r.x >>> s;
        o.flip = r.flip;
        if (!r.z[31]) begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - atan_units(s);
        end else begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + atan_units(s);
        end
        return o;
    endfunction

    logic w_adv;
    t_rot r_a [STAGES+1];
    t_rot r_b [STAGES+1];
    logic r_v [STAGES+1];
    logic r_sv;
    t_sum r_sum;
    t_comp w_xa, w_ya, w_xb, w_yb;

    assign w_adv  = !i_full;
    assign o_busy = i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_start;
        end
        if (w_adv) begin
            r_a[0] <= rot_prep(i_req.mag_a, i_req.angle_a);
            r_b[0] <= rot_prep(i_req.mag_b, i_req.angle_b);
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_v[k+1] <= r_v[k];
            end
            if (w_adv) begin
                r_a[k+1] <= rot_step(r_a[k], 5'(k));
                r_b[k+1] <= rot_step(r_b[k], 5'(k));
            end
        end
    end

    always_comb begin
        w_xa = r_a[STAGES].flip ? -r_a[STAGES].x : r_a[STAGES].x;
        w_ya = r_a[STAGES].flip ? -r_a[STAGES].y : r_a[STAGES].y;
        w_xb = r_b[STAGES].flip ? -r_b[STAGES].x : r_b[STAGES].x;
        w_yb = r_b[STAGES].flip ? -r_b[STAGES].y : r_b[STAGES].y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (w_adv) begin
            r_sv <= r_v[STAGES];
        end
        if (w_adv) begin
            r_sum.x <= w_xa + w_xb;
            r_sum.y <= w_ya + w_yb;
        end
    end

    assign o_push = r_sv && w_adv;
    assign o_sum  = r_sum;

endmodule

### hw/rtl/pva_queue.sv
`include "polar_vector_add_defines.svh"

module pva_queue import pva_pkg::*; #(
    parameter int DEPTH = QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_sum i_data,
    output logic o_full,
    output logic o_vld,
    output t_sum o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_sum          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [NW-1:0] r_cnt;
    logic          r_vld;
    t_sum          r_rdata;
    logic          w_empty, w_push, w_pop;

    assign w_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == NW'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = !w_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
        r_rdata <= r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= w_pop;
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + NW'(w_push) - NW'(w_pop);
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_rdata;

    `PVA_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= NW'(DEPTH))
    `PVA_ASSERT_NEXT(a_pop_gives_data, w_pop, o_vld)
    `PVA_ASSERT_NEXT(a_cnt_grows, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

### hw/rtl/pva_back.sv
module pva_back import pva_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_sum i_sum,
    output logic o_done,
    output t_res o_res
);

    localparam logic [31:0] GAIN = cordic_gain(STAGES);
    localparam int HW = CW - 32;

    function automatic t_vec vec_step(input t_vec v, input logic [4:0] s);
        t_vec  o;
        t_comp dx;
        t_comp dy;
        dx = v.y >>> s;
        dy = v.x >>> s;
        o.zero = v.zero;
        if (!v.y[CW-1]) begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + atan_units(s);
        end else begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - atan_units(s);
        end
        return o;
    endfunction

    t_vec r_s [STAGES+1];
    logic r_v [STAGES+1];
    t_vec w_prep;

    logic              r_mv;
    logic [63:0]       r_plo;
    logic [HW+31:0]    r_phi;
    logic [31:0]       r_mz;
    logic              r_mzero;
    logic [HW+32:0]    w_t;
    logic [HW+16:0]    w_m;

    logic r_done;
    t_res r_res;

    always_comb begin
        w_prep.zero = (i_sum.x == '0) && (i_sum.y == '0);
        if (i_sum.x < 0) begin
            w_prep.x = -i_sum.x;
            w_prep.y = -i_sum.y;
            w_prep.z = ANG_PI;
        end else begin
            w_prep.x = i_sum.x;
            w_prep.y = i_sum.y;
            w_prep.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
        end
        r_s[0] <= w_prep;
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_s[k+1] <= vec_step(r_s[k], 5'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_v[STAGES];
        end
        r_plo   <= 64'(r_s[STAGES].x[31:0]) * 64'(GAIN);
        r_phi   <= (HW+32)'(r_s[STAGES].x[CW-1:32]) * (HW+32)'(GAIN);
        r_mz    <= r_s[STAGES].z + ANG_HALF;
        r_mzero <= r_s[STAGES].zero;
    end

    assign w_t = (HW+33)'(r_phi) + (HW+33)'(r_plo[63:32]);
    assign w_m = w_t[HW+32:GUARD_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_mv;
        end
        if (r_mzero) begin
            r_res <= '0;
        end else begin
            r_res.sum_mag   <= (w_m > (HW+17)'(1 << MAG_BITS)) ?
                               (MAG_BITS+1)'(1 << MAG_BITS) : w_m[MAG_BITS:0];
            r_res.sum_angle <= r_mz[31:ANG_SHIFT];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### hw/rtl/polar_vector_add.sv
// Channel  Handshake          Payload
// request  i_start / o_busy   i_req (t_req)
// result   o_done strobe      o_res (t_res)
//
// One request a cycle while o_busy is low; o_busy rises only if the queue
// between the rotation and vectoring pipelines fills.
// A request passes in turn through the rotation pipeline, the queue and the vectoring
// and scaling pipeline.
// The vectoring side never stalls, so results leave in request order.
// Synchronous active-low reset clears valid flags, queue pointers and the queue count only.
module polar_vector_add import pva_pkg::*; #(
    parameter int CORDIC_STAGES = STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_res o_res
);

    logic w_push, w_full, w_qvld;
    t_sum w_sum, w_qdata;

    pva_front #(.STAGES(CORDIC_STAGES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_busy  (o_busy),
        .o_push  (w_push),
        .o_sum   (w_sum)
    );

    pva_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_sum),
        .o_full  (w_full),
        .o_vld   (w_qvld),
        .o_data  (w_qdata)
    );

    pva_back #(.STAGES(CORDIC_STAGES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_qvld),
        .i_sum   (w_qdata),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

### sim/polar_vector_add_test.sv
module polar_vector_add_test import pva_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STAGES  = STAGES_DEF;
    localparam int LATENCY     = 2 * NUM_STAGES + 7 + QDEPTH;
    localparam int RANDOM_REQS = 1950;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_res o_res;

    t_res sum_queue[$];
    int   fail_count;

    typedef struct {
        t_req req;
        logic known;
        t_res res;
    } t_row;

    t_row rows[$];

    polar_vector_add #(.CORDIC_STAGES(NUM_STAGES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL polar_vector_add");
        $finish;
    end

    function automatic logic [63:0] shift_down(logic [63:0] v, int s);
        return v[63] ? ~((~v) >> s) : (v >> s);
    endfunction

    function automatic logic [31:0] arctan_step(int s);
        logic [31:0] tbl [0:31];
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return tbl[s & 31];
    endfunction

    function automatic void polar_to_xy(input logic signed [MAG_BITS-1:0] mag,
                                        input logic [ANGLE_BITS-1:0] ang,
                                        output logic [63:0] xo,
                                        output logic [63:0] yo);
        logic [63:0] m, x, y, dx, dy;
        logic [31:0] z;
        logic flip;
        m = 64'(signed'(mag));
        flip = m[63];
        x = (flip ? -m : m) << GUARD_BITS;
        y = '0;
        z = 32'(ang) << (32 - ANGLE_BITS);
        if (z[31] != z[30]) begin
            x = -x;
            z = z - ANG_PI;
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            dx = shift_down(y, i);
            dy = shift_down(x, i);
            if (!z[31]) begin
                x = x - dx; y = y + dy; z = z - arctan_step(i);
            end else begin
                x = x + dx; y = y - dy; z = z + arctan_step(i);
            end
        end
        xo = flip ? -x : x;
        yo = flip ? -y : y;
    endfunction

    function automatic t_res predict_sum(t_req r);
        logic [63:0] xa, ya, xb, yb, x, y, dx, dy, g, mag;
        logic [31:0] z;
        t_res res;
        polar_to_xy(r.mag_a, r.angle_a, xa, ya);
        polar_to_xy(r.mag_b, r.angle_b, xb, yb);
        x = xa + xb;
        y = ya + yb;
        if (x == 0 && y == 0) return '0;
        z = '0;
        if (x[63]) begin
            x = -x; y = -y; z = ANG_PI;
        end
        g = 64'd1 << 32;
        for (int i = 0; i < NUM_STAGES; i++) begin
            dx = shift_down(y, i);
            dy = shift_down(x, i);
            if (!y[63]) begin
                x = x + dx; y = y - dy; z = z + arctan_step(i);
            end else begin
                x = x - dx; y = y + dy; z = z - arctan_step(i);
            end
            g = g - g / ((64'd1 << (2 * (i & 31))) + 64'd1);
        end
        mag = (((x >> 32) * g) + (((x & 64'hFFFF_FFFF) * g) >> 32)) >> GUARD_BITS;
        if (mag > (64'd1 << MAG_BITS)) mag = 64'd1 << MAG_BITS;
        res.sum_mag = mag[MAG_BITS:0];
        res.sum_angle = 16'((z + ANG_HALF) >> ANG_SHIFT);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (sum_queue.size() == 0) begin
                $error("unexpected result mag=%0d angle=%0d", o_res.sum_mag, o_res.sum_angle);
                fail_count++;
            end else begin
                if (o_res.sum_mag !== sum_queue[0].sum_mag) begin
                    $error("sum_mag expected %0d actual %0d", sum_queue[0].sum_mag,
                           o_res.sum_mag);
                    fail_count++;
                end
                if (o_res.sum_angle !== sum_queue[0].sum_angle) begin
                    $error("sum_angle expected %0d actual %0d", sum_queue[0].sum_angle,
                           o_res.sum_angle);
                    fail_count++;
                end
                void'(sum_queue.pop_front());
            end
        end
    end

    task automatic send_request(t_req r, t_res res);
        @(negedge i_clk);
        i_req   <= r;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sum_queue.push_back(res);
    endtask

    task automatic add_row(int ma, int aa, int mb, int ab, logic known, int m, int a);
        t_row row;
        row.req = '{16'(ma), 16'(aa), 16'(mb), 16'(ab)};
        row.known = known;
        row.res = '{17'(m), 16'(a)};
        rows.push_back(row);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(signed'($urandom_range(0, 64)) - 32);
            3: return {2'($urandom_range(0, 3)), 14'h0};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_req r;
        int burst;
        fail_count = 0;
        i_start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(0, 0, 0, 0, 1, 0, 0);
        add_row(1000, 100, -1000, 100, 1, 0, 0);
        add_row(-32768, -32768, 32767, -32768, 0, 0, 0);
        add_row(32767, 0, 32767, 0, 0, 0, 0);
        add_row(-32768, 0, -32768, 0, 0, 0, 0);
        add_row(32767, 16384, 32767, 16384, 0, 0, 0);
        add_row(1000, -16384, 0, 0, 0, 0, 0);
        add_row(1000, 32767, 500, -32768, 0, 0, 0);
        add_row(-1000, 0, 0, 0, 0, 0, 0);
        add_row(1000, 0, 1000, 16384, 0, 0, 0);
        add_row(1, 8192, 1, 24576, 0, 0, 0);
        add_row(20000, -8192, -20000, 24576, 0, 0, 0);
        add_row(32767, 12345, -32768, 12345, 0, 0, 0);
        add_row(5, -24576, 7, 24576, 0, 0, 0);

        foreach (rows[k]) begin
            send_request(rows[k].req,
                         rows[k].known ? rows[k].res : predict_sum(rows[k].req));
        end
        @(negedge i_clk);
        i_start <= 1'b0;

        for (int n = 0; n < RANDOM_REQS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_REQS; b++, n++) begin
                r = '{rand_field(), rand_field(), rand_field(), rand_field()};
                send_request(r, predict_sum(r));
            end
            @(negedge i_clk);
            i_start <= 1'b0;
            if (n > RANDOM_REQS / 2 && n - burst <= RANDOM_REQS / 2) begin
                wait (sum_queue.size() == 0);
            end else if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end
        end

        wait (sum_queue.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS polar_vector_add");
        end else begin
            $display("FAIL polar_vector_add");
        end
        $finish;
    end
endmodule
